// ----- sv/bbcd_pkg.sv -----
// Shared constants, payload structs and codes for the Bayer BGGR color
// difference block. No dependencies; imported by every module in sv/.
`default_nettype none

package bbcd_pkg;

  // Frame geometry in half-resolution units.
  localparam int HALF_WIDTH  = 320;
  localparam int HALF_HEIGHT = 240;
  localparam int FULL_WIDTH  = 2 * HALF_WIDTH;
  localparam int FULL_HEIGHT = 2 * HALF_HEIGHT;

  localparam int COL_W  = $clog2(FULL_WIDTH);
  localparam int ROW_W  = $clog2(FULL_HEIGHT);
  localparam int SLOT_W = (HALF_WIDTH > 1) ? $clog2(HALF_WIDTH) : 1;

  localparam int PIX_W = 8;

  // Result queue between the difference stage and the output port.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TARGET_COLOR = 1'b0;  // word index, paddr[2]

  // target_color codes.
  localparam logic COLOR_R_MINUS_B = 1'b0;
  localparam logic COLOR_B_MINUS_R = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] diff;
    logic             row_end;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [SLOT_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } line_req_t;

endpackage

`default_nettype wire

// ----- sv/bbcd_line_store.sv -----
// Half-width line store holding the blue samples of the last even row.
// Single port, registered read. Depends on bbcd_pkg.
`default_nettype none

module bbcd_line_store (
  input  wire                          clk,
  input  wire bbcd_pkg::line_req_t     req,
  output logic [bbcd_pkg::PIX_W-1:0]   rdata
);
  import bbcd_pkg::*;

  logic [PIX_W-1:0] mem [HALF_WIDTH];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/bbcd_out_queue.sv -----
// Small result queue that decouples the difference stage from the output
// stall. Depends on bbcd_pkg for result_t and the queue sizes.
`default_nettype none

module bbcd_out_queue (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  input  wire bbcd_pkg::result_t       push_data,
  input  wire                          pop,
  output logic                         head_valid,
  output bbcd_pkg::result_t            head,
  output logic [bbcd_pkg::QCNT_W-1:0]  count
);
  import bbcd_pkg::*;

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

endmodule

`default_nettype wire

// ----- sv/bayer_bg_color_difference.sv -----
// Bayer BGGR color difference, top level. Uses bbcd_pkg, bbcd_line_store
// and bbcd_out_queue.
//
// Pixel channel (pixel_valid / pixel_stall / pixel_value) takes a raw BGGR
// frame of 2*HALF_WIDTH x 2*HALF_HEIGHT pixels in raster order, one beat per
// pixel. Blue samples (even row, even column) go into a half-width line
// store; each red sample (odd row, odd column) reads the blue sample of the
// same half-resolution column and yields one beat on the result channel
// (result_valid / result_stall): red minus blue, or blue minus red when
// target_color is set, clamped at zero. row_end marks the last result of a
// half-resolution row, frame_end the last of the frame. Green pixels yield
// nothing.
// Timing: one pixel per clock sustained while pixel_stall is low; the line
// store serves one access per pixel. A red pixel's result is registered in
// the difference stage and then in the result queue before it is valid.
// Reset: rst clears the counters, target_color and the queue, not the store.
// Stall: results pile up in a four-deep queue; pixel_stall rises once that
// queue and the difference stage together hold four results.
// Registers: target_color at byte address 0, bit 0.
`default_nettype none

module bayer_bg_color_difference (
  input  wire                               clk,
  input  wire                               rst,
  // register port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [bbcd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [bbcd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bbcd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  // pixel channel
  input  wire                               pixel_valid,
  output logic                              pixel_stall,
  input  wire  [bbcd_pkg::PIX_W-1:0]        pixel_value,
  // result channel
  output logic                              result_valid,
  input  wire                               result_stall,
  output logic [bbcd_pkg::PIX_W-1:0]        color_difference,
  output logic                              row_end,
  output logic                              frame_end
);
  import bbcd_pkg::*;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  logic target_color;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_color <= COLOR_R_MINUS_B;
    end else if (psel && penable && pwrite && paddr[2] == REG_TARGET_COLOR) begin
      target_color <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TARGET_COLOR) begin
      prdata[0] = target_color;
    end
  end

  // ---------------------------------------------------------------------
  // Raster position
  // ---------------------------------------------------------------------
  logic             accept;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             last_col;
  logic             last_row;
  logic             is_blue;
  logic             is_red;

  assign accept   = pixel_valid && !pixel_stall;
  assign last_col = (col == COL_W'(FULL_WIDTH - 1));
  assign last_row = (row == ROW_W'(FULL_HEIGHT - 1));
  assign is_blue  = !row[0] && !col[0];
  assign is_red   = row[0] && col[0];

  // Advance column per beat; wrap the column and advance the row at line end, wrap both at frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line store: write blue, read for red. A blue write and the red read of
  // the same slot are always separated by at least one green pixel, so the
  // read never overlaps a pending write and needs no forwarding.
  // ---------------------------------------------------------------------
  line_req_t        line_req;
  logic [PIX_W-1:0] blue_rdata;

  always_comb begin
    line_req.wr    = accept && is_blue;
    line_req.rd    = accept && is_red;
    line_req.addr  = SLOT_W'(col >> 1);
    line_req.wdata = pixel_value;
  end

  bbcd_line_store u_line_store (
    .clk   (clk),
    .req   (line_req),
    .rdata (blue_rdata)
  );

  // ---------------------------------------------------------------------
  // Difference stage: red and flags wait here while the blue read lands.
  // ---------------------------------------------------------------------
  logic             s1_valid;
  logic [PIX_W-1:0] s1_red;
  logic             s1_color;
  logic             s1_row_end;
  logic             s1_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && is_red;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_red) begin
      s1_red       <= pixel_value;
      s1_color     <= target_color;
      s1_row_end   <= last_col;
      s1_frame_end <= last_col && last_row;
    end
  end

  result_t s1_result;

  always_comb begin
    s1_result.row_end   = s1_row_end;
    s1_result.frame_end = s1_frame_end;
    if (s1_color == COLOR_R_MINUS_B) begin
      s1_result.diff = (s1_red > blue_rdata) ? s1_red - blue_rdata : '0;
    end else begin
      s1_result.diff = (blue_rdata > s1_red) ? blue_rdata - s1_red : '0;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue and output handshake
  // ---------------------------------------------------------------------
  logic              pop;
  result_t           head;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W-1:0] in_flight;

  assign pop = result_valid && !result_stall;

  bbcd_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_data  (s1_result),
    .pop        (pop),
    .head_valid (result_valid),
    .head       (head),
    .count      (q_count)
  );

  // Hold off pixels once a further red one could overflow the queue.
  assign in_flight   = q_count + QCNT_W'(s1_valid);
  assign pixel_stall = (in_flight > QCNT_W'(QUEUE_DEPTH - 1));

  assign color_difference = head.diff;
  assign row_end          = head.row_end;
  assign frame_end        = head.frame_end;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_red_only: assert property (@(posedge clk) disable iff (rst)
    !(accept && is_red) |=> !s1_valid)
    else $error("result produced for a non-red pixel");

  a_red_result: assert property (@(posedge clk) disable iff (rst)
    (accept && is_red) |=> s1_valid)
    else $error("red pixel produced no result");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_end) |-> row_end)
    else $error("frame end without row end");

endmodule

`default_nettype wire
